// ----- rtl/core/sitda_pkg.sv -----
// ----------------------------------------------------------------------------
// sitda_pkg: shared constants and a helper function for decimal text conversion
// Character codes and the conversion parameter default.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int CHAR_BITS = 6;
  localparam logic [5:0] CHAR_ZERO = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  // Number of BCD digits needed for a magnitude of the given width
  function automatic int digit_count(input int bits);
    int d;
    longint unsigned lim;
    begin
      d = 1;
      lim = 10;
      while ((bits < 64) && (lim <= (64'd1 << bits)) && (d < 20)) begin
        d = d + 1;
        lim = lim * 10;
      end
      if (bits >= 64) d = 20;
      digit_count = d;
    end
  endfunction

endpackage

// ----- rtl/core/sitda_if.sv -----
// ----------------------------------------------------------------------------
// sitda_if: valid/ready channel
// Carries valid, ready and a payload of parameterised width.
// ----------------------------------------------------------------------------
interface sitda_if #(
  parameter int WIDTH = 32
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sitda_conv.sv -----
// ----------------------------------------------------------------------------
// sitda_conv: magnitude to BCD converter
// Double-dabble pipeline, one bit per stage, valid bits travel with the data.
// ----------------------------------------------------------------------------
module sitda_conv #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT,
  parameter int DIGITS = sitda_pkg::digit_count(VALUE_BITS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_neg,
  output logic [4*DIGITS-1:0]   out_bcd
);

  localparam int STAGES = VALUE_BITS;

  logic                  stg_valid [STAGES+1];
  logic                  stg_neg   [STAGES+1];
  logic [VALUE_BITS-1:0] stg_mag   [STAGES+1];
  logic [4*DIGITS-1:0]   stg_bcd   [STAGES+1];
  logic                  stg_adv   [STAGES+1];

  // Stage zero is the input: take sign and magnitude
  always_comb begin
    stg_valid[0] = in_valid;
    stg_neg[0]   = in_value[VALUE_BITS-1];
    stg_mag[0]   = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
    stg_bcd[0]   = '0;
  end

  // Advance a stage when the next one is empty or moving
  assign stg_adv[STAGES] = out_ready || !stg_valid[STAGES];
  assign in_ready = stg_adv[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [4*DIGITS-1:0] adj;
    always_comb begin
      adj = stg_bcd[s];
      for (int d = 0; d < DIGITS; d++) begin
        if (adj[4*d +: 4] >= 4'd5) adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    assign stg_adv[s] = stg_adv[s+1] || !stg_valid[s+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s+1] <= 1'b0;
      end else if (stg_adv[s]) begin
        stg_valid[s+1] <= stg_valid[s];
      end
      if (stg_adv[s]) begin
        stg_neg[s+1] <= stg_neg[s];
        stg_mag[s+1] <= {stg_mag[s][VALUE_BITS-2:0], 1'b0};
        stg_bcd[s+1] <= {adj[4*DIGITS-2:0], stg_mag[s][VALUE_BITS-1]};
      end
    end
  end

  assign out_valid = stg_valid[STAGES];
  assign out_neg   = stg_neg[STAGES];
  assign out_bcd   = stg_bcd[STAGES];

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal text
// Emits one ASCII character per item, most significant first.
// ----------------------------------------------------------------------------
//  channel    dir   payload
//  value_in   in    value[31:0] signed
//  char_out   out   character[5:0], last
//
// The double-dabble pipeline takes one magnitude bit per stage. The
// serialiser sends up to 11 characters per number and loads the next number
// only after the last character of the previous one is taken, so the
// serialiser sets the rate. Reset clears all valid bits. A stall on the output
// holds each full stage with no empty stage after it; bubbles still close up.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sitda_if.sink     value_in,
  sitda_if.source   char_out
);

  localparam int DIGITS = sitda_pkg::digit_count(VALUE_BITS);
  localparam int IDX_BITS = $clog2(DIGITS);

  logic                cv_valid;
  logic                cv_ready;
  logic                cv_neg;
  logic [4*DIGITS-1:0] cv_bcd;

  sitda_conv #(.VALUE_BITS(VALUE_BITS), .DIGITS(DIGITS)) u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (value_in.valid),
    .in_ready  (value_in.ready),
    .in_value  (value_in.data[VALUE_BITS-1:0]),
    .out_valid (cv_valid),
    .out_ready (cv_ready),
    .out_neg   (cv_neg),
    .out_bcd   (cv_bcd)
  );

  // Serialiser registers and decode signals
  logic                busy;
  logic                sign_pend;
  logic [4*DIGITS-1:0] bcd;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] top;
  logic [3:0]          dig;
  logic                fire;

  // Find the leading nonzero digit of the incoming number
  always_comb begin
    top = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (cv_bcd[4*d +: 4] != 4'd0) top = IDX_BITS'(d);
    end
  end

  assign cv_ready = !busy;
  assign dig = bcd[4*idx +: 4];
  assign fire = busy && char_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      if (cv_valid) begin
        busy      <= 1'b1;
        sign_pend <= cv_neg;
        bcd       <= cv_bcd;
        idx       <= top;
      end
    end else if (fire) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  assign char_out.valid = busy;
  assign char_out.data  = {(sign_pend ? sitda_pkg::CHAR_MINUS
                                      : sitda_pkg::CHAR_ZERO + {2'b00, dig}),
                           (!sign_pend && idx == '0)};

endmodule

// ----- rtl/core/sitda_check.sv -----
// ----------------------------------------------------------------------------
// sitda_check: port checker for the decimal text block
// Watches the ports and bound to the top level.
// ----------------------------------------------------------------------------
module sitda_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_data
);

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  // Characters are digits or minus
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[6:1] == sitda_pkg::CHAR_MINUS ||
                   (out_data[6:1] >= sitda_pkg::CHAR_ZERO &&
                    out_data[6:1] <= sitda_pkg::CHAR_ZERO + 6'd9)))
    else $error("bad character");

  // Minus never ends a number
  a_minus: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[6:1] == sitda_pkg::CHAR_MINUS |-> !out_data[0])
    else $error("minus marked last");

  // After a minus comes a nonzero digit
  a_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data[6:1] == sitda_pkg::CHAR_MINUS
      |=> out_valid && out_data[6:1] != sitda_pkg::CHAR_ZERO &&
          out_data[6:1] != sitda_pkg::CHAR_MINUS)
    else $error("bad character after minus");

endmodule

bind signed_int_to_decimal_ascii sitda_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (char_out.valid),
  .out_ready (char_out.ready),
  .out_data  (char_out.data)
);

// ----- tb/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii: self-checking bench for decimal text output
// Feeds signed integers through a valid/ready channel and checks every
// character and last flag against a predictor of the decimal text.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

  localparam int NUM_RANDOM = 405;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [31:0] value;
    bit          typed;
    string       text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sitda_if #(.WIDTH(32)) value_ch ();
  sitda_if #(.WIDTH(7))  char_ch ();

  signed_int_to_decimal_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .value_in (value_ch),
    .char_out (char_ch)
  );

  always #5 clk = ~clk;

  char_item_t  expected_chars[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          hold_sink = 1'b0;
  bit          hold_done = 1'b0;
  stim_row_t   rows[$];

  // Form the decimal text of a value into the queue of expected characters
  function automatic void predict_text(input logic [31:0] v);
    logic [32:0] mag;
    logic [3:0]  digs[$];
    logic        neg;
    char_item_t  c;
    neg = v[31];
    mag = neg ? {1'b0, (~v + 32'd1)} : {1'b0, v};
    do begin
      digs.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      c.character = sitda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = 0; k < digs.size(); k++) begin
      c.character = sitda_pkg::CHAR_ZERO + 6'(digs[k]);
      c.last = (k == digs.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Check typed-in text against the predictor's own output
  function automatic void check_typed(input logic [31:0] v, input string s);
    int base;
    base = expected_chars.size();
    predict_text(v);
    if (expected_chars.size() - base != s.len()) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed %0d: length %0d, table says %s", $signed(v),
                 expected_chars.size() - base, s);
    end else begin
      for (int i = 0; i < s.len(); i++)
        if (expected_chars[base + i].character != 6'(s[i])) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed %0d: table text %s differs", $signed(v), s);
        end
    end
  endfunction

  function automatic void add_row(input logic [31:0] v, input string s);
    stim_row_t r;
    r.value = v;
    r.typed = (s.len() != 0);
    r.text = s;
    rows.push_back(r);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 9));
      1: return 32'(-$signed(32'($urandom_range(1, 999))));
      2: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** signed_int_to_decimal_ascii: FAILED **");
      $finish;
    end
  end

  // Check each accepted character against the oldest expectation
  always @(posedge clk) begin
    char_item_t got, want;
    if (!rst && char_ch.valid && char_ch.ready) begin
      got = char_ch.data;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %0d last %0b", got.character, got.last);
      end else begin
        want = expected_chars.pop_front();
        if (got.character !== want.character || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char: expected %0d/%0b, got %0d/%0b", want.character,
                     want.last, got.character, got.last);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none when calm
  initial begin
    int gap;
    char_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        char_ch.ready <= 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(negedge clk);
        hold_done = 1'b1;
        hold_sink = 1'b0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 10);
        char_ch.ready <= 1'b0;
        for (int i = 0; i < gap; i++) @(negedge clk);
      end else begin
        char_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one value and wait for acceptance; valid stays up afterwards
  task automatic send_value(input logic [31:0] v, input bit typed, input string s);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      value_ch.valid <= 1'b0;
      for (int i = 0; i < gap; i++) @(negedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.data <= v;
    @(posedge clk);
    while (!value_ch.ready) @(posedge clk);
    if (typed) check_typed(v, s);
    else predict_text(v);
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int wait_cycles;
    value_ch.valid = 1'b0;
    value_ch.data = '0;
    add_row(32'd0, "0");
    add_row(32'd1, "1");
    add_row(32'hFFFF_FFFF, "-1");
    add_row(32'd9, "9");
    add_row(32'd10, "10");
    add_row(32'hFFFF_FFF6, "-10");
    add_row(32'h7FFF_FFFF, "2147483647");
    add_row(32'h8000_0000, "-2147483648");
    add_row(32'h8000_0001, "-2147483647");
    add_row(32'd1000000000, "1000000000");
    add_row(32'd999999999, "999999999");
    add_row(32'hAAAA_AAAA, "");
    add_row(32'h5555_5555, "");
    add_row(32'd12345, "");
    add_row(32'hFFFF_0000, "");

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_value(rows[i].value, rows[i].typed, rows[i].text);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 100) begin
        // Let the sender pause until every result has drained
        value_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_chars.size() != 0) @(negedge clk);
      end
      if (n == 200) hold_sink = 1'b1;
      if (n == 330) calm = 1'b1;
      send_value(random_value(), 1'b0, "");
    end
    value_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_chars.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (60) @(negedge clk);

    if (mismatches == 0 && expected_chars.size() == 0 && hold_done) begin
      $display("** signed_int_to_decimal_ascii: PASSED **");
    end else begin
      if (expected_chars.size() != 0)
        $display("%0d characters never arrived", expected_chars.size());
      $display("** signed_int_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sitda_pkg.sv
rtl/core/sitda_if.sv
rtl/core/sitda_conv.sv
rtl/core/signed_int_to_decimal_ascii.sv
rtl/core/sitda_check.sv
tb/tb_signed_int_to_decimal_ascii.sv
